/* rtl/cascaded_interrupt_controller_defines.svh */
// assertion macros shared by the interrupt controller rtl
`ifndef CASCADED_INTERRUPT_CONTROLLER_DEFINES_SVH
`define CASCADED_INTERRUPT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define CIC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define CIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CIC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/cic_pkg.sv */
// types, codes and constants of the cascaded interrupt controller
package cic_pkg;

   // item kinds
   localparam logic [2:0] MODE_WRITE   = 3'd0;
   localparam logic [2:0] MODE_READ    = 3'd1;
   localparam logic [2:0] MODE_RAISE   = 3'd2;
   localparam logic [2:0] MODE_LOWER   = 3'd3;
   localparam logic [2:0] MODE_ACK     = 3'd4;
   localparam logic [2:0] MODE_RELEASE = 3'd5;

   // port decode
   localparam logic [7:0] PORT_MASK   = 8'hFE;
   localparam logic [7:0] SLAVE_BASE  = 8'hA0;
   localparam logic [7:0] MASTER_BASE = 8'h20;

   // command word decode
   localparam logic [7:0] ICW1_FLAG  = 8'h10;
   localparam logic [7:0] OCW3_MASK  = 8'h98;
   localparam logic [7:0] OCW3_MATCH = 8'h08;
   localparam int         EOI_BIT    = 5;
   localparam int         RR_BIT     = 1;
   localparam int         RIS_BIT    = 0;
   localparam int         SNGL_BIT   = 1;
   localparam int         IC4_BIT    = 0;
   localparam int         AEOI_BIT   = 1;

   // init words written by the xt fixups
   localparam logic [7:0] XT_MASTER_ICW3 = 8'h04;
   localparam logic [7:0] XT_SLAVE_ICW3  = 8'h02;
   localparam logic [7:0] XT_ICW4        = 8'h01;
   localparam logic [7:0] XT_SLAVE_ICW2  = 8'h70;
   localparam logic [7:0] CASCADE_OFFSET = 8'h02;

   // init stages
   localparam logic [2:0] STAGE_ICW2 = 3'd1;
   localparam logic [2:0] STAGE_ICW3 = 3'd2;
   localparam logic [2:0] STAGE_ICW4 = 3'd3;
   localparam logic [2:0] STAGE_DONE = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_RESP
   } seq_state_type;

   typedef enum logic {
      SCAN_ACK,
      SCAN_EOI
   } scan_kind_type;

   typedef struct packed {
      logic          req_ready;
      logic          capture;
      logic          execute;
      logic          ack_apply;
      logic          eoi_apply;
      logic          rsp_valid;
      logic          start_scan;
      logic          prio_order;
      scan_kind_type kind;
   } seq_ctl_type;

   typedef struct packed {
      logic need_ack_scan;
      logic need_eoi_scan;
      logic auto_eoi;
   } dp_stat_type;

   typedef struct packed {
      logic       done;
      logic       found;
      logic [3:0] line;
   } scan_res_type;

   // fixed acknowledge order: 0,1,2, then the slave lines, then 3..7
   function automatic logic [3:0] prio_line(input logic [3:0] pos);
      logic [3:0] line;
      case (pos)
         4'd0:    line = 4'd0;
         4'd1:    line = 4'd1;
         4'd2:    line = 4'd2;
         4'd3:    line = 4'd8;
         4'd4:    line = 4'd9;
         4'd5:    line = 4'd10;
         4'd6:    line = 4'd11;
         4'd7:    line = 4'd12;
         4'd8:    line = 4'd13;
         4'd9:    line = 4'd14;
         4'd10:   line = 4'd15;
         4'd11:   line = 4'd3;
         4'd12:   line = 4'd4;
         4'd13:   line = 4'd5;
         4'd14:   line = 4'd6;
         4'd15:   line = 4'd7;
         default: line = 4'd0;
      endcase
      return line;
   endfunction

endpackage

/* rtl/cic_scan.sv */
// shared bit scan unit: tests one line of a 16-bit word per cycle
`include "cascaded_interrupt_controller_defines.svh"

module cic_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  prio_order,
   input  logic [15:0]           word,
   output cic_pkg::scan_res_type res
);
   import cic_pkg::*;

   logic       busy_ff, busy_in;
   logic [3:0] pos_ff, pos_in;
   logic       order_ff, order_in;
   logic [3:0] line;
   logic       hit;
   logic       last;

   always_comb begin
      line     = order_ff ? prio_line(pos_ff) : pos_ff;
      hit      = word[line];
      // plain order only looks at the low byte
      last     = order_ff ? (pos_ff == 4'd15) : (pos_ff[2:0] == 3'd7);
      res.done  = busy_ff && (hit || last);
      res.found = busy_ff && hit;
      res.line  = line;
   end

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      order_in = order_ff;
      if (start) begin
         busy_in  = 1'b1;
         pos_in   = 4'd0;
         order_in = prio_order;
      end else if (res.done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         pos_in = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      order_ff <= order_in;
   end

   `CIC_ASSERT_NEXT(a_scan_start, clock, reset, start, busy_ff && pos_ff == 4'd0, "scan did not start at position zero")
   `CIC_ASSERT_NEXT(a_scan_step, clock, reset, busy_ff && !res.done && !start, busy_ff && pos_ff == $past(pos_ff) + 4'd1, "scan skipped a position")

endmodule

/* rtl/cic_seq.sv */
// sequencer: capture, execute, bit scans and result transfer
`include "cascaded_interrupt_controller_defines.svh"

module cic_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   input  cic_pkg::dp_stat_type  stat,
   input  cic_pkg::scan_res_type scan,
   output cic_pkg::seq_ctl_type  ctl
);
   import cic_pkg::*;

   seq_state_type state_ff, state_in;
   scan_kind_type kind_ff, kind_in;

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (stat.need_ack_scan) begin
               state_in = ST_SCAN;
               kind_in  = SCAN_ACK;
            end else if (stat.need_eoi_scan) begin
               state_in = ST_SCAN;
               kind_in  = SCAN_EOI;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (scan.done) begin
               // auto-eoi follows the acknowledge with a second scan
               if (kind_ff == SCAN_ACK && stat.auto_eoi) begin
                  kind_in = SCAN_EOI;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl      = '0;
      ctl.kind = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
            ctl.capture   = req_valid;
         end
         ST_EXEC: begin
            ctl.execute    = 1'b1;
            ctl.start_scan = stat.need_ack_scan || stat.need_eoi_scan;
            ctl.prio_order = stat.need_ack_scan;
         end
         ST_SCAN: begin
            if (scan.done) begin
               ctl.ack_apply  = (kind_ff == SCAN_ACK);
               ctl.eoi_apply  = (kind_ff == SCAN_EOI);
               ctl.start_scan = (kind_ff == SCAN_ACK) && stat.auto_eoi;
            end
         end
         ST_RESP: begin
            ctl.rsp_valid = 1'b1;
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= SCAN_ACK;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   `CIC_ASSERT_NEXT(a_seq_scan_follows, clock, reset, ctl.start_scan, state_ff == ST_SCAN, "scan started outside the scan state")
   `CIC_ASSERT_IMPL(a_seq_done_in_scan, clock, reset, scan.done, state_ff == ST_SCAN, "scan finished while the sequencer was not waiting")

endmodule

/* rtl/cascaded_interrupt_controller.sv */
// top level: master/slave interrupt controller pair with its register state
//
// Master and slave 8259-style controllers behind one request channel. Each item
// (port write, port read, raise or lower a line, acknowledge, release of the held
// vector) gives exactly one result. An item is captured in the idle state and
// executed in the next cycle, and a plain item's result is offered in the cycle
// after that. Priority resolution and in-service clearing run through one shared
// bit-scan unit that tests one line per cycle: an acknowledge with no vector held
// searches the 16 lines in priority order and, with auto-EOI, then scans the 8
// in-service bits; a non-specific EOI command scans the 8 in-service bits.
// The block takes a new item only after the previous result has been transferred.
// The xt_fixups register is written through csr_write_en/csr_write_data.
`include "cascaded_interrupt_controller_defines.svh"

module cascaded_interrupt_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_port,
   input  logic [7:0]  req_data,
   input  logic [3:0]  req_irq,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_handled,
   output logic [7:0]  rsp_read_data,
   output logic [7:0]  rsp_vector,
   output logic        rsp_ack_found,
   output logic [3:0]  rsp_ack_irq,
   output logic        rsp_eoi_done,
   output logic [3:0]  rsp_eoi_irq,
   output logic        rsp_int_pending
);
   import cic_pkg::*;

   seq_ctl_type  ctl;
   dp_stat_type  stat;
   scan_res_type scan;
   logic [15:0]  scan_word;

   // captured item
   logic [2:0]  mode_ff, mode_in;
   logic [15:0] port_ff, port_in;
   logic [7:0]  data_ff, data_in;
   logic [3:0]  irq_ff, irq_in;

   // controller state
   logic                 xt_ff;
   logic [1:0][7:0]      irr_ff, irr_in;
   logic [1:0][7:0]      isr_ff, isr_in;
   logic [1:0][7:0]      imr_ff, imr_in;
   logic [1:0]           ris_ff, ris_in;
   logic [7:0][7:0]      icw_ff, icw_in;
   logic [1:0][2:0]      stage_ff, stage_in;
   logic                 held_ff, held_in;
   logic [7:0]           hvec_ff, hvec_in;
   logic                 eoi_ctl_ff, eoi_ctl_in;

   // result
   logic       handled_ff, handled_in;
   logic [7:0] rdata_ff, rdata_in;
   logic [7:0] vec_ff, vec_in;
   logic       found_ff, found_in;
   logic [3:0] airq_ff, airq_in;
   logic       eoi_done_ff, eoi_done_in;
   logic [3:0] eoi_irq_ff, eoi_irq_in;

   // decode
   logic       sel_hit;
   logic       sel_c;
   logic       is_ocw3;
   logic       slave_en;
   logic [7:0] pend0;
   logic [7:0] pend1;
   logic       ack_pc;
   logic [2:0] ack_ir;
   logic [7:0] ack_vec;

   always_comb begin
      sel_hit  = ((port_ff[7:0] & PORT_MASK) == SLAVE_BASE) ||
                 ((port_ff[7:0] & PORT_MASK) == MASTER_BASE);
      sel_c    = ((port_ff[7:0] & PORT_MASK) == SLAVE_BASE);
      is_ocw3  = ((data_ff & OCW3_MASK) == OCW3_MATCH);
      slave_en = !icw_ff[0][SNGL_BIT] && (icw_ff[2] == XT_MASTER_ICW3) &&
                 (icw_ff[6] == XT_SLAVE_ICW3);
      pend0    = irr_ff[0] & ~imr_ff[0] & ~isr_ff[0];
      pend1    = slave_en ? (irr_ff[1] & ~imr_ff[1] & ~isr_ff[1]) : 8'h00;
      ack_pc   = scan.line[3];
      ack_ir   = scan.line[2:0];
      // irq9 is wired to the master's ir2
      if (ack_pc && ack_ir == 3'd1) begin
         ack_vec = icw_ff[1] + CASCADE_OFFSET;
      end else begin
         ack_vec = icw_ff[{ack_pc, 2'd1}] + {5'd0, ack_ir};
      end
      scan_word = (ctl.kind == SCAN_ACK) ? {pend1, pend0} : {8'h00, isr_ff[eoi_ctl_ff]};
      stat.need_ack_scan = (mode_ff == MODE_ACK) && !held_ff;
      stat.need_eoi_scan = (mode_ff == MODE_WRITE) && sel_hit && !port_ff[0] &&
                           !(|(data_ff & ICW1_FLAG)) && !is_ocw3 && data_ff[EOI_BIT];
      stat.auto_eoi      = scan.found && icw_ff[{ack_pc, 2'd3}][AEOI_BIT];
   end

   cic_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .scan      (scan),
      .ctl       (ctl)
   );

   cic_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (ctl.start_scan),
      .prio_order (ctl.prio_order),
      .word       (scan_word),
      .res        (scan)
   );

   always_comb begin
      logic [2:0] st;
      st          = 3'd0;
      mode_in     = mode_ff;
      port_in     = port_ff;
      data_in     = data_ff;
      irq_in      = irq_ff;
      irr_in      = irr_ff;
      isr_in      = isr_ff;
      imr_in      = imr_ff;
      ris_in      = ris_ff;
      icw_in      = icw_ff;
      stage_in    = stage_ff;
      held_in     = held_ff;
      hvec_in     = hvec_ff;
      eoi_ctl_in  = eoi_ctl_ff;
      handled_in  = handled_ff;
      rdata_in    = rdata_ff;
      vec_in      = vec_ff;
      found_in    = found_ff;
      airq_in     = airq_ff;
      eoi_done_in = eoi_done_ff;
      eoi_irq_in  = eoi_irq_ff;

      if (ctl.capture) begin
         mode_in     = req_mode;
         port_in     = req_port;
         data_in     = req_data;
         irq_in      = req_irq;
         handled_in  = 1'b0;
         rdata_in    = 8'h00;
         vec_in      = 8'h00;
         found_in    = 1'b0;
         airq_in     = 4'd0;
         eoi_done_in = 1'b0;
         eoi_irq_in  = 4'd0;
      end

      if (ctl.execute) begin
         case (mode_ff)
            MODE_WRITE: begin
               if (sel_hit) begin
                  handled_in = 1'b1;
                  eoi_ctl_in = sel_c;
                  if (port_ff[0]) begin
                     st = stage_ff[sel_c];
                     if (st == STAGE_ICW3 && icw_ff[{sel_c, 2'd0}][SNGL_BIT]) begin
                        st = STAGE_ICW4;
                        if (xt_ff && !sel_c) begin
                           icw_in[2] = XT_MASTER_ICW3;
                           icw_in[6] = XT_SLAVE_ICW3;
                        end
                     end
                     if (st == STAGE_ICW4 && !icw_ff[{sel_c, 2'd0}][IC4_BIT]) begin
                        st = STAGE_DONE;
                        icw_in[{sel_c, 2'd3}] = 8'h00;
                        if (xt_ff && !sel_c) begin
                           icw_in[3] = XT_ICW4;
                           icw_in[7] = XT_ICW4;
                        end
                     end
                     if (st < STAGE_DONE) begin
                        if (st == STAGE_ICW2 && xt_ff && !sel_c) icw_in[5] = XT_SLAVE_ICW2;
                        // a data write before any icw1 lands in icw1
                        icw_in[{sel_c, st[1:0]}] = data_ff;
                        st = st + 3'd1;
                     end else begin
                        icw_in[0][SNGL_BIT] = 1'b0;
                        imr_in[sel_c]       = data_ff;
                     end
                     stage_in[sel_c] = st;
                  end else if (|(data_ff & ICW1_FLAG)) begin
                     stage_in[sel_c]       = STAGE_ICW2;
                     imr_in[sel_c]         = 8'h00;
                     icw_in[{sel_c, 2'd0}] = data_ff;
                  end else if (is_ocw3 && data_ff[RR_BIT]) begin
                     ris_in[sel_c] = data_ff[RIS_BIT];
                  end
               end
            end
            MODE_READ: begin
               if (sel_hit) begin
                  handled_in = 1'b1;
                  if (port_ff[0]) begin
                     rdata_in = imr_ff[sel_c];
                  end else begin
                     rdata_in = ris_ff[sel_c] ? isr_ff[sel_c] : irr_ff[sel_c];
                  end
               end
            end
            MODE_RAISE: irr_in[irq_ff[3]][irq_ff[2:0]] = 1'b1;
            MODE_LOWER: irr_in[irq_ff[3]][irq_ff[2:0]] = 1'b0;
            MODE_ACK: begin
               if (held_ff) vec_in = hvec_ff;
            end
            MODE_RELEASE: held_in = 1'b0;
            default: held_in = held_ff;
         endcase
      end

      if (ctl.ack_apply) begin
         held_in = 1'b1;
         if (scan.found) begin
            irr_in[ack_pc][ack_ir] = 1'b0;
            isr_in[ack_pc][ack_ir] = 1'b1;
            hvec_in    = ack_vec;
            vec_in     = ack_vec;
            found_in   = 1'b1;
            airq_in    = scan.line;
            eoi_ctl_in = ack_pc;
         end else begin
            hvec_in = 8'h00;
            vec_in  = 8'h00;
         end
      end

      // lowest set in-service bit of the selected controller
      if (ctl.eoi_apply && scan.found) begin
         isr_in[eoi_ctl_ff][scan.line[2:0]] = 1'b0;
         eoi_done_in = 1'b1;
         eoi_irq_in  = {eoi_ctl_ff, scan.line[2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xt_ff    <= 1'b0;
         irr_ff   <= '0;
         isr_ff   <= '0;
         imr_ff   <= '0;
         ris_ff   <= '0;
         icw_ff   <= '0;
         stage_ff <= '0;
         held_ff  <= 1'b0;
         hvec_ff  <= 8'h00;
      end else begin
         if (csr_write_en) xt_ff <= csr_write_data;
         irr_ff   <= irr_in;
         isr_ff   <= isr_in;
         imr_ff   <= imr_in;
         ris_ff   <= ris_in;
         icw_ff   <= icw_in;
         stage_ff <= stage_in;
         held_ff  <= held_in;
         hvec_ff  <= hvec_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      port_ff     <= port_in;
      data_ff     <= data_in;
      irq_ff      <= irq_in;
      eoi_ctl_ff  <= eoi_ctl_in;
      handled_ff  <= handled_in;
      rdata_ff    <= rdata_in;
      vec_ff      <= vec_in;
      found_ff    <= found_in;
      airq_ff     <= airq_in;
      eoi_done_ff <= eoi_done_in;
      eoi_irq_ff  <= eoi_irq_in;
   end

   assign req_ready       = ctl.req_ready;
   assign rsp_valid       = ctl.rsp_valid;
   assign rsp_handled     = handled_ff;
   assign rsp_read_data   = rdata_ff;
   assign rsp_vector      = vec_ff;
   assign rsp_ack_found   = found_ff;
   assign rsp_ack_irq     = airq_ff;
   assign rsp_eoi_done    = eoi_done_ff;
   assign rsp_eoi_irq     = eoi_irq_ff;
   // state is frozen while the result waits, so this reflects the finished item
   assign rsp_int_pending = (|pend0) || held_ff || (|pend1);

   `CIC_ASSERT_NEXT(a_top_held_stable, clock, reset, !ctl.execute && !ctl.ack_apply, $stable(held_ff), "held vector flag changed outside execute or acknowledge")
   `CIC_ASSERT_NEXT(a_top_isr_idle, clock, reset, ctl.req_ready, $stable(isr_ff), "in-service bits changed while idle")

endmodule

/* verif/testbench.sv */
// testbench of the cascaded interrupt controller pair: directed table, then random traffic
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cic_pkg::*;

   localparam int IDLE_PCT      = 24;
   localparam int PHASES        = 4;
   localparam int PHASE_ITEMS   = 280;
   localparam int QUIET_ITEMS   = 150;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 40;
   localparam int NO_CTRL       = 2;

   localparam logic [2:0]  MODE_SPARE6  = 3'd6;
   localparam logic [2:0]  MODE_SPARE7  = 3'd7;
   localparam logic [3:0]  CASCADE_IRQ  = 4'd9;
   localparam logic [7:0]  CMD_EOI      = 8'h20;
   localparam logic [7:0]  CMD_READ_ISR = 8'h0B;
   localparam logic [15:0] MASTER_CMD   = {8'h00, MASTER_BASE};
   localparam logic [15:0] MASTER_DATA  = {8'h00, MASTER_BASE | 8'h01};
   localparam logic [15:0] SLAVE_CMD    = {8'h00, SLAVE_BASE};
   localparam logic [15:0] SLAVE_DATA   = {8'h00, SLAVE_BASE | 8'h01};

   // fixed acknowledge order: master 0..2, slave lines, master 3..7
   localparam int ACK_ORDER [16] = '{0, 1, 2, 8, 9, 10, 11, 12, 13, 14, 15, 3, 4, 5, 6, 7};

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] port;
      logic [7:0]  data;
      logic [3:0]  irq;
   } pic_access_type;

   typedef struct packed {
      logic       handled;
      logic [7:0] read_data;
      logic [7:0] vector;
      logic       ack_found;
      logic [3:0] ack_irq;
      logic       eoi_done;
      logic [3:0] eoi_irq;
      logic       int_pending;
   } pic_result_type;

   typedef struct packed {
      pic_access_type acc;
      logic           typed;
      pic_result_type want;
   } table_row_type;

   localparam pic_result_type NO_RESULT = '0;
   localparam pic_result_type PORT_HIT  = '{handled: 1'b1, default: '0};
   localparam pic_result_type HELD_ZERO = '{int_pending: 1'b1, default: '0};

   localparam int DIRECTED_COUNT = 27;
   localparam table_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{MODE_READ,    MASTER_CMD,   8'h00,        4'd0},  1'b1, PORT_HIT},
      '{'{MODE_READ,    16'hFFFF,     8'h00,        4'd0},  1'b1, NO_RESULT},
      '{'{MODE_ACK,     16'h0000,     8'h00,        4'd0},  1'b1, HELD_ZERO},
      '{'{MODE_ACK,     16'h0000,     8'h00,        4'd0},  1'b1, HELD_ZERO},
      '{'{MODE_RELEASE, 16'h0000,     8'h00,        4'd0},  1'b1, NO_RESULT},
      '{'{MODE_SPARE6,  16'h0000,     8'h00,        4'd0},  1'b1, NO_RESULT},
      '{'{MODE_SPARE7,  16'hFFFF,     8'hFF,        4'd15}, 1'b1, NO_RESULT},
      // data byte before any init word lands in the slave's first init word
      '{'{MODE_WRITE,   SLAVE_DATA,   8'h5A,        4'd0},  1'b1, PORT_HIT},
      '{'{MODE_WRITE,   MASTER_CMD,   8'h11,        4'd0},  1'b1, PORT_HIT},
      '{'{MODE_WRITE,   MASTER_DATA,  8'h08,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   MASTER_DATA,  8'h04,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   MASTER_DATA,  8'h01,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   SLAVE_CMD,    8'h11,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   SLAVE_DATA,   8'h70,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   SLAVE_DATA,   8'h02,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   SLAVE_DATA,   8'h03,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_RAISE,   16'h0000,     8'h00,        4'd15}, 1'b0, NO_RESULT},
      '{'{MODE_RAISE,   16'h0000,     8'h00,        4'd9},  1'b0, NO_RESULT},
      '{'{MODE_RAISE,   16'h0000,     8'h00,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_ACK,     16'h0000,     8'h00,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_RELEASE, 16'h0000,     8'h00,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_ACK,     16'h0000,     8'h00,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_RELEASE, 16'h0000,     8'h00,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   MASTER_CMD,   CMD_READ_ISR, 4'd0},  1'b0, NO_RESULT},
      '{'{MODE_READ,    MASTER_CMD,   8'h00,        4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   MASTER_CMD,   CMD_EOI,      4'd0},  1'b0, NO_RESULT},
      '{'{MODE_WRITE,   MASTER_DATA,  8'hFF,        4'd0},  1'b0, NO_RESULT}
   };

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_write_en   = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode       = '0;
   logic [15:0] req_port       = '0;
   logic [7:0]  req_data       = '0;
   logic [3:0]  req_irq        = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic        rsp_handled;
   logic [7:0]  rsp_read_data;
   logic [7:0]  rsp_vector;
   logic        rsp_ack_found;
   logic [3:0]  rsp_ack_irq;
   logic        rsp_eoi_done;
   logic [3:0]  rsp_eoi_irq;
   logic        rsp_int_pending;

   // controller state as the checker sees it
   bit [7:0] irr_m [2];
   bit [7:0] isr_m [2];
   bit [7:0] imr_m [2];
   bit       ris_m [2];
   bit [7:0] icw_m [8];
   bit [2:0] stage_m [2];
   bit       vec_held_m;
   bit [7:0] held_vec_m;
   bit       xt_m;
   bit       eoi_hit_m;
   bit [3:0] eoi_line_m;

   pic_result_type awaited_results [$];
   int             mismatches  = 0;
   int             items_done  = 0;
   int             cycle_count = 0;
   bit             quiet       = 1'b0;

   cascaded_interrupt_controller i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_port        (req_port),
      .req_data        (req_data),
      .req_irq         (req_irq),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_handled     (rsp_handled),
      .rsp_read_data   (rsp_read_data),
      .rsp_vector      (rsp_vector),
      .rsp_ack_found   (rsp_ack_found),
      .rsp_ack_irq     (rsp_ack_irq),
      .rsp_eoi_done    (rsp_eoi_done),
      .rsp_eoi_irq     (rsp_eoi_irq),
      .rsp_int_pending (rsp_int_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // non-specific eoi: clear the lowest in-service bit of one controller
   function automatic void retire_lowest(int c);
      bit done = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!done && isr_m[c][i]) begin
            isr_m[c][i] = 1'b0;
            eoi_hit_m = 1'b1;
            eoi_line_m = 4'(c * 8 + i);
            done = 1'b1;
         end
      end
   endfunction

   // slave lines only count while the cascade is set up on both sides
   function automatic bit [7:0] live_lines(int c);
      if (c == 1 && (icw_m[0][SNGL_BIT] || icw_m[2] != XT_MASTER_ICW3
                     || icw_m[6] != XT_SLAVE_ICW3))
         return '0;
      return irr_m[c] & ~imr_m[c] & ~isr_m[c];
   endfunction

   function automatic int decode_port(logic [15:0] port);
      if ((port[7:0] & PORT_MASK) == SLAVE_BASE) return 1;
      if ((port[7:0] & PORT_MASK) == MASTER_BASE) return 0;
      return NO_CTRL;
   endfunction

   function automatic void data_word(int c, logic [7:0] v);
      int base = c * 4;
      if (stage_m[c] == STAGE_ICW3 && icw_m[base][SNGL_BIT]) begin
         stage_m[c] = STAGE_ICW4;
         if (xt_m && c == 0) begin
            icw_m[2] = XT_MASTER_ICW3;
            icw_m[6] = XT_SLAVE_ICW3;
         end
      end
      if (stage_m[c] == STAGE_ICW4 && !icw_m[base][IC4_BIT]) begin
         stage_m[c] = STAGE_DONE;
         icw_m[base + 3] = '0;
         if (xt_m && c == 0) begin
            icw_m[3] = XT_ICW4;
            icw_m[7] = XT_ICW4;
         end
      end
      if (stage_m[c] < STAGE_DONE) begin
         if (stage_m[c] == STAGE_ICW2 && xt_m && c == 0)
            icw_m[5] = XT_SLAVE_ICW2;
         icw_m[base + int'(stage_m[c][1:0])] = v;
         stage_m[c] = stage_m[c] + 3'd1;
      end else begin
         icw_m[0][SNGL_BIT] = 1'b0;
         imr_m[c] = v;
      end
   endfunction

   function automatic void cmd_word(int c, logic [7:0] v);
      if ((v & ICW1_FLAG) != 8'h00) begin
         stage_m[c] = STAGE_ICW2;
         imr_m[c] = '0;
         icw_m[c * 4] = v;
      end else if ((v & OCW3_MASK) == OCW3_MATCH) begin
         if (v[RR_BIT]) ris_m[c] = v[RIS_BIT];
      end else if (v[EOI_BIT]) begin
         retire_lowest(c);
      end
   endfunction

   function automatic pic_result_type next_pic_result(pic_access_type a);
      pic_result_type r;
      int             c;
      int             pc;
      bit [3:0]       line;
      bit [7:0]       live;
      r = '0;
      eoi_hit_m = 1'b0;
      eoi_line_m = '0;
      case (a.mode)
         MODE_WRITE: begin
            c = decode_port(a.port);
            if (c != NO_CTRL) begin
               r.handled = 1'b1;
               if (a.port[0]) data_word(c, a.data);
               else cmd_word(c, a.data);
            end
         end
         MODE_READ: begin
            c = decode_port(a.port);
            if (c != NO_CTRL) begin
               r.handled = 1'b1;
               if (a.port[0]) r.read_data = imr_m[c];
               else r.read_data = ris_m[c] ? isr_m[c] : irr_m[c];
            end
         end
         MODE_RAISE: irr_m[a.irq[3]][a.irq[2:0]] = 1'b1;
         MODE_LOWER: irr_m[a.irq[3]][a.irq[2:0]] = 1'b0;
         MODE_ACK: begin
            if (vec_held_m) begin
               r.vector = held_vec_m;
            end else begin
               held_vec_m = '0;
               for (int i = 0; i < 16; i++) begin
                  line = 4'(ACK_ORDER[i]);
                  pc = int'(line[3]);
                  live = live_lines(pc);
                  if (!r.ack_found && live[line[2:0]]) begin
                     irr_m[pc][line[2:0]] = 1'b0;
                     isr_m[pc][line[2:0]] = 1'b1;
                     if (icw_m[pc * 4 + 3][AEOI_BIT]) retire_lowest(pc);
                     // the slave line on the cascade input takes the master base plus the cascade offset
                     if (line == CASCADE_IRQ) held_vec_m = icw_m[1] + CASCADE_OFFSET;
                     else held_vec_m = icw_m[pc * 4 + 1] + 8'(line[2:0]);
                     r.ack_found = 1'b1;
                     r.ack_irq = line;
                  end
               end
               vec_held_m = 1'b1;
               r.vector = held_vec_m;
            end
         end
         MODE_RELEASE: vec_held_m = 1'b0;
         default: ;
      endcase
      r.eoi_done = eoi_hit_m;
      r.eoi_irq = eoi_line_m;
      r.int_pending = (|live_lines(0)) || vec_held_m || (|live_lines(1));
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      pic_result_type want;
      if (!reset) begin
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: rsp transfer with no result outstanding", $time);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("handled", 8'(want.handled), 8'(rsp_handled));
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("vector", want.vector, rsp_vector);
               check_field("ack_found", 8'(want.ack_found), 8'(rsp_ack_found));
               check_field("ack_irq", 8'(want.ack_irq), 8'(rsp_ack_irq));
               check_field("eoi_done", 8'(want.eoi_done), 8'(rsp_eoi_done));
               check_field("eoi_irq", 8'(want.eoi_irq), 8'(rsp_eoi_irq));
               check_field("int_pending", 8'(want.int_pending), 8'(rsp_int_pending));
            end
         end
      end
   end

   function automatic pic_access_type access(logic [2:0] mode, logic [15:0] port,
                                             logic [7:0] data, logic [3:0] irq);
      pic_access_type a;
      a.mode = mode;
      a.port = port;
      a.data = data;
      a.irq = irq;
      return a;
   endfunction

   // controller port, now and then with junk in the upper byte (still decodes)
   function automatic logic [15:0] ctrl_port(int c, bit a0);
      logic [7:0] hi;
      hi = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00;
      return {hi, (c == 1 ? SLAVE_BASE : MASTER_BASE) | {7'b0, a0}};
   endfunction

   task automatic issue(input pic_access_type a, input bit typed, input pic_result_type want);
      pic_result_type predicted;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= a.mode;
      req_port <= a.port;
      req_data <= a.data;
      req_irq <= a.irq;
      do @(posedge clock); while (!req_ready);
      predicted = next_pic_result(a);
      awaited_results.push_back(typed ? want : predicted);
      if (a.mode <= MODE_RELEASE) items_done++;
   endtask

   task automatic send(input pic_access_type a);
      issue(a, 1'b0, NO_RESULT);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_xt(input bit v);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      xt_m = v;
      csr_write_en <= 1'b0;
   endtask

   // init sequence with random words; now and then cut short
   task automatic init_controller(input int c);
      logic [7:0] icw1;
      logic [7:0] icw3;
      bit         sngl;
      bit         ic4;
      int         stop;
      sngl = (c == 0) ? ($urandom_range(4) == 0) : ($urandom_range(9) == 0);
      ic4 = ($urandom_range(3) != 0);
      icw1 = 8'($urandom_range(255)) | ICW1_FLAG;
      icw1[SNGL_BIT] = sngl;
      icw1[IC4_BIT] = ic4;
      stop = ($urandom_range(6) == 0) ? $urandom_range(3) : 4;
      send(access(MODE_WRITE, ctrl_port(c, 1'b0), icw1, 4'($urandom_range(15))));
      if (stop > 0)
         send(access(MODE_WRITE, ctrl_port(c, 1'b1), 8'($urandom_range(255)), '0));
      if (stop > 1 && !sngl) begin
         if ($urandom_range(9) == 0) icw3 = 8'($urandom_range(255));
         else icw3 = (c == 1) ? XT_SLAVE_ICW3 : XT_MASTER_ICW3;
         send(access(MODE_WRITE, ctrl_port(c, 1'b1), icw3, '0));
      end
      if (stop > 2 && ic4)
         send(access(MODE_WRITE, ctrl_port(c, 1'b1), 8'($urandom_range(255)), '0));
      if (stop > 3 && $urandom_range(1) == 1)
         send(access(MODE_WRITE, ctrl_port(c, 1'b1),
                     8'($urandom_range(255) & $urandom_range(255) & $urandom_range(255)), '0));
   endtask

   task automatic random_action();
      int         pick;
      int         c;
      logic [7:0] v;
      pick = $urandom_range(99);
      c = $urandom_range(1);
      v = 8'($urandom_range(255));
      if (pick < 6) begin
         init_controller(c);
      end else if (pick < 28) begin
         send(access(MODE_RAISE, 16'($urandom_range(65535)), v, 4'($urandom_range(15))));
      end else if (pick < 35) begin
         send(access(MODE_LOWER, 16'($urandom_range(65535)), v, 4'($urandom_range(15))));
      end else if (pick < 52) begin
         send(access(MODE_ACK, 16'($urandom_range(65535)), v, 4'($urandom_range(15))));
         if ($urandom_range(4) != 0) send(access(MODE_RELEASE, '0, '0, '0));
      end else if (pick < 57) begin
         send(access(MODE_RELEASE, 16'($urandom_range(65535)), v, 4'($urandom_range(15))));
      end else if (pick < 66) begin
         if ($urandom_range(1) == 1) v = CMD_EOI;
         else v = (v & ~ICW1_FLAG) | CMD_EOI;
         send(access(MODE_WRITE, ctrl_port(c, 1'b0), v, '0));
      end else if (pick < 72) begin
         send(access(MODE_WRITE, ctrl_port(c, 1'b0), (v & ~OCW3_MASK) | OCW3_MATCH, '0));
      end else if (pick < 84) begin
         send(access(MODE_READ, ctrl_port(c, 1'($urandom_range(1))), v, '0));
      end else if (pick < 90) begin
         send(access(MODE_WRITE, ctrl_port(c, 1'b1), v & 8'($urandom_range(255)), '0));
      end else begin
         // noise: any kind, any port, any byte
         send(access(3'($urandom_range(7)),
                     $urandom_range(1) ? 16'($urandom_range(65535))
                                       : ctrl_port(c, 1'($urandom_range(1))),
                     v, 4'($urandom_range(15))));
      end
   endtask

   initial begin : stimulus
      int phase_start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_xt(1'b0);
      for (int i = 0; i < DIRECTED_COUNT; i++)
         issue(DIRECTED_ROWS[i].acc, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         write_xt(ph % 2 == 0);
         phase_start = items_done;
         quiet = (ph == 2);
         init_controller(0);
         init_controller(1);
         while (items_done - phase_start < PHASE_ITEMS) begin
            quiet = (ph == 2) && (items_done - phase_start < QUIET_ITEMS);
            random_action();
            // occasionally hold off until everything outstanding has come back
            if ($urandom_range(49) == 0) drain();
         end
         quiet = 1'b0;
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
